// ----- rtl/lav_pkg.sv -----
`default_nettype none
package lav_pkg;

  localparam int CoordBits = 32;
  localparam int DiffBits  = 33;
  localparam int VecBits   = 64;
  localparam int MagBits   = 30;
  localparam int LenBits   = 31;
  localparam int MulBits   = 34;

  typedef struct packed {
    logic signed [2:0][CoordBits-1:0] eye;
    logic signed [2:0][CoordBits-1:0] upv;
    logic signed [2:0][DiffBits-1:0]  dir;
  } lav_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_SCALE,
    ST_SQ,
    ST_SQACC,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_XMUL,
    ST_XACC,
    ST_DMUL,
    ST_DACC,
    ST_EMIT
  } lav_state_e;

  // Cyclic successor indexes of a vector component, for cross products.
  function automatic logic [1:0] idx_next1(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] idx_next2(input logic [1:0] c);
    logic [1:0] r;
    case (c)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/look_at_view_matrix.sv -----
`default_nettype none
// Left-handed look-at view matrix in signed fixed point (FRAC_BITS fraction
// bits). Each transfer on the input channel carries eye, target and an
// approximate up vector; the block answers with four row transfers, rows 0
// to 3 in order, last_row_o marking row 3. Rows 0 to 2 hold the x, y, z
// components of the right, up and look unit vectors, row 3 the saturated
// negated dot products with the eye. A zero-length basis vector gives
// identity rows with degenerate_o set. The front subtracts eye from target
// and drops the setup into a two-entry queue, so up to two setups wait while
// the back works; the back runs one setup at a time on a single shared
// 34x34 multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle
// divider.
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] upvec_x_i,
  input  logic signed [31:0] upvec_y_i,
  input  logic signed [31:0] upvec_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col_first_o,
  output logic signed [31:0] col_second_o,
  output logic signed [31:0] col_third_o,
  output logic               degenerate_o,
  output logic               last_row_o
);
  import lav_pkg::*;

  logic signed [2:0][CoordBits-1:0] eye, tgt, upv;
  logic      q_full, q_push, q_valid, q_pop;
  lav_item_t q_in, q_out;

  // Pack the coordinate ports into vectors, component 0 = x.
  assign eye = {eye_z_i, eye_y_i, eye_x_i};
  assign tgt = {target_z_i, target_y_i, target_x_i};
  assign upv = {upvec_z_i, upvec_y_i, upvec_x_i};

  // Front: take a setup whenever the queue has room.
  lav_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .eye_i      (eye),
    .target_i   (tgt),
    .upv_i      (upv),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  // Queue between front and back.
  lav_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_out)
  );

  // Back: normalize, cross, dot, then emit through the output register.
  lav_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .col_first_o  (col_first_o),
    .col_second_o (col_second_o),
    .col_third_o  (col_third_o),
    .degenerate_o (degenerate_o),
    .last_row_o   (last_row_o)
  );

endmodule
`default_nettype wire

// ----- rtl/lav_front.sv -----
`default_nettype none
module lav_front (
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [2:0][lav_pkg::CoordBits-1:0] eye_i,
  input  logic signed [2:0][lav_pkg::CoordBits-1:0] target_i,
  input  logic signed [2:0][lav_pkg::CoordBits-1:0] upv_i,
  input  logic                                     q_full_i,
  output logic                                     q_push_o,
  output lav_pkg::lav_item_t                       q_item_o
);
  import lav_pkg::*;

  // Form the view direction on entry; the back end only sees target - eye.
  always_comb begin
    q_item_o.eye = eye_i;
    q_item_o.upv = upv_i;
    for (int i = 0; i < 3; i++) begin
      q_item_o.dir[i] = DiffBits'(signed'(target_i[i])) - DiffBits'(signed'(eye_i[i]));
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule
`default_nettype wire

// ----- rtl/lav_queue.sv -----
`default_nettype none
module lav_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lav_pkg::lav_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output lav_pkg::lav_item_t item_o
);
  import lav_pkg::*;

  lav_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lav_back.sv -----
`default_nettype none
module lav_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  lav_pkg::lav_item_t        item_i,
  output logic                      item_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                row_index_o,
  output logic signed [31:0]        col_first_o,
  output logic signed [31:0]        col_second_o,
  output logic signed [31:0]        col_third_o,
  output logic                      degenerate_o,
  output logic                      last_row_o
);
  import lav_pkg::*;

  localparam int NW  = FRAC_BITS + 2;
  localparam int QB  = FRAC_BITS + 1;
  localparam int DNW = MagBits + FRAC_BITS + 1;
  localparam int ItBits = $clog2(QB);

  lav_state_e state_q, state_d;

  logic signed [2:0][CoordBits-1:0] eye_q, upv_q;
  logic signed [VecBits-1:0] vec_q [3];
  logic [VecBits-1:0]        mag_q [3];
  logic [2:0]                neg_q;
  logic signed [NW-1:0]      look_q [3];
  logic signed [NW-1:0]      right_q [3];
  logic signed [NW-1:0]      up_q [3];
  logic signed [31:0]        tr_q [3];
  logic [1:0]  stg_q, dv_q, dc_q, row_q;
  logic [4:0]  cnt_q;
  logic [ItBits-1:0] it_q;
  logic [VecBits-1:0] sum_q, sx_q, sres_q, sbit_q;
  logic [LenBits-1:0] len_q, rem_q;
  logic [QB-1:0] nlo_q, quo_q;
  logic signed [VecBits-1:0] acc_q;
  logic deg_q;
  logic signed [2*MulBits-1:0] prod_q;
  logic signed [MulBits-1:0]   mul_a, mul_b;

  logic [VecBits-1:0] mx01, mx;
  logic scale_done, vec_zero, load_en, out_valid_q;
  logic [1:0] xc, ia, ib;
  logic [VecBits-1:0] trial;
  logic sq_ge;
  logic [DNW-1:0] num;
  logic [LenBits:0] r2;
  logic dge;
  logic [QB-1:0] quo_fin;
  logic signed [NW-1:0] q_pos, unit_val;
  logic signed [VecBits-1:0] acc_sum, t_rnd, f_flr, r_neg;
  logic signed [31:0] tr_val;
  logic signed [NW-1:0] u_sel;
  logic signed [31:0] row_c0, row_c1, row_c2;

  // Largest magnitude and scaling decision.
  always_comb begin
    mx01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    mx   = (mx01 > mag_q[2]) ? mx01 : mag_q[2];
    scale_done = (mx[VecBits-1:MagBits] == '0) && mx[MagBits-1];
    vec_zero = (vec_q[0] == '0) && (vec_q[1] == '0) && (vec_q[2] == '0);
  end

  // Cross product operand order.
  always_comb begin
    xc = cnt_q[2:1];
    ia = cnt_q[0] ? idx_next2(xc) : idx_next1(xc);
    ib = cnt_q[0] ? idx_next1(xc) : idx_next2(xc);
  end

  always_comb begin
    case (dv_q)
      2'd0:    u_sel = right_q[dc_q];
      2'd1:    u_sel = up_q[dc_q];
      default: u_sel = look_q[dc_q];
    endcase
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = signed'(MulBits'(mag_q[cnt_q[1:0]][MagBits-1:0]));
        mul_b = mul_a;
      end
      ST_XMUL: begin
        if (stg_q == 2'd1) begin
          mul_a = MulBits'(signed'(upv_q[ia]));
          mul_b = MulBits'(look_q[ib]);
        end else begin
          mul_a = MulBits'(look_q[ia]);
          mul_b = MulBits'(right_q[ib]);
        end
      end
      ST_DMUL: begin
        mul_a = MulBits'(u_sel);
        mul_b = MulBits'(signed'(eye_q[dc_q]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Square root step, division step, translation rounding.
  always_comb begin
    trial   = sres_q + sbit_q;
    sq_ge   = sx_q >= trial;
    num     = (DNW'(mag_q[cnt_q[1:0]][MagBits-1:0]) << FRAC_BITS) + DNW'(len_q >> 1);
    r2      = {rem_q, nlo_q[QB-1]};
    dge     = r2 >= {1'b0, len_q};
    quo_fin = {quo_q[QB-2:0], dge};
    q_pos   = signed'({1'b0, quo_fin});
    unit_val = neg_q[cnt_q[1:0]] ? -q_pos : q_pos;
    acc_sum = (dc_q == 2'd0) ? prod_q[VecBits-1:0] : acc_q + prod_q[VecBits-1:0];
    t_rnd   = acc_sum + (VecBits'(1) << (FRAC_BITS - 1));
    f_flr   = t_rnd >>> FRAC_BITS;
    r_neg   = -f_flr;
    if (r_neg > 64'sd2147483647) begin
      tr_val = 32'sh7fffffff;
    end else if (r_neg < -64'sd2147483648) begin
      tr_val = 32'sh80000000;
    end else begin
      tr_val = r_neg[31:0];
    end
  end

  // Row under emission.
  always_comb begin
    if (deg_q) begin
      row_c0 = (row_q == 2'd0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      row_c1 = (row_q == 2'd1) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      row_c2 = (row_q == 2'd2) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    end else if (row_q == 2'd3) begin
      row_c0 = tr_q[0];
      row_c1 = tr_q[1];
      row_c2 = tr_q[2];
    end else begin
      row_c0 = 32'(right_q[row_q]);
      row_c1 = 32'(up_q[row_q]);
      row_c2 = 32'(look_q[row_q]);
    end
  end

  assign load_en = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_pop_o = item_valid_i;
        if (item_valid_i) state_d = ST_ABS;
      end
      ST_ABS:   state_d = vec_zero ? ST_EMIT : ST_SCALE;
      ST_SCALE: if (scale_done) state_d = ST_SQ;
      ST_SQ:    state_d = ST_SQACC;
      ST_SQACC: state_d = (cnt_q == 5'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT:  if (cnt_q == 5'd31) state_d = ST_DINIT;
      ST_DINIT: state_d = ST_DIV;
      ST_DIV: begin
        if (it_q == ItBits'(QB - 1)) begin
          if (cnt_q != 5'd2)       state_d = ST_DINIT;
          else if (stg_q == 2'd2)  state_d = ST_DMUL;
          else                     state_d = ST_XMUL;
        end
      end
      ST_XMUL:  state_d = ST_XACC;
      ST_XACC:  state_d = (cnt_q == 5'd5) ? ST_ABS : ST_XMUL;
      ST_DMUL:  state_d = ST_DACC;
      ST_DACC:  state_d = (dv_q == 2'd2 && dc_q == 2'd2) ? ST_EMIT : ST_DMUL;
      ST_EMIT:  if (load_en && row_q == 2'd3) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_en)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (load_en) begin
      row_index_o  <= row_q;
      col_first_o  <= row_c0;
      col_second_o <= row_c1;
      col_third_o  <= row_c2;
      degenerate_o <= deg_q;
      last_row_o   <= row_q == 2'd3;
      row_q        <= row_q + 2'd1;
    end
    case (state_q)
      ST_IDLE: begin
        eye_q <= item_i.eye;
        upv_q <= item_i.upv;
        for (int i = 0; i < 3; i++) vec_q[i] <= VecBits'(signed'(item_i.dir[i]));
        stg_q <= 2'd0;
        deg_q <= 1'b0;
        row_q <= 2'd0;
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vec_q[i][VecBits-1] ? VecBits'(-vec_q[i]) : VecBits'(vec_q[i]);
          neg_q[i] <= vec_q[i][VecBits-1];
        end
        if (vec_zero) deg_q <= 1'b1;
      end
      ST_SCALE: begin
        // Bring the largest magnitude into [2^29, 2^30), coarse steps first.
        for (int i = 0; i < 3; i++) begin
          if (mx[VecBits-1:MagBits+8] != '0)       mag_q[i] <= mag_q[i] >> 8;
          else if (mx[VecBits-1:MagBits] != '0)    mag_q[i] <= mag_q[i] >> 1;
          else if (mx[VecBits-1:MagBits-9] == '0)  mag_q[i] <= mag_q[i] << 8;
          else if (!mx[MagBits-1])                 mag_q[i] <= mag_q[i] << 1;
        end
        cnt_q <= 5'd0;
        sum_q <= '0;
      end
      ST_SQACC: begin
        sum_q <= sum_q + prod_q[VecBits-1:0];
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd2) begin
          sx_q   <= sum_q + prod_q[VecBits-1:0];
          sres_q <= '0;
          sbit_q <= VecBits'(1) << 62;
          cnt_q  <= 5'd0;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sx_q   <= sx_q - trial;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          len_q <= sq_ge ? LenBits'((sres_q >> 1) + sbit_q) : LenBits'(sres_q >> 1);
          cnt_q <= 5'd0;
        end
      end
      ST_DINIT: begin
        rem_q <= LenBits'(num >> QB);
        nlo_q <= num[QB-1:0];
        quo_q <= '0;
        it_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= dge ? LenBits'(r2 - {1'b0, len_q}) : r2[LenBits-1:0];
        nlo_q <= nlo_q << 1;
        quo_q <= quo_fin;
        it_q  <= it_q + ItBits'(1);
        if (it_q == ItBits'(QB - 1)) begin
          case (stg_q)
            2'd0:    look_q[cnt_q[1:0]]  <= unit_val;
            2'd1:    right_q[cnt_q[1:0]] <= unit_val;
            default: up_q[cnt_q[1:0]]    <= unit_val;
          endcase
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) begin
            cnt_q <= 5'd0;
            stg_q <= stg_q + 2'd1;
            dv_q  <= 2'd0;
            dc_q  <= 2'd0;
          end
        end
      end
      ST_XACC: begin
        vec_q[xc] <= cnt_q[0] ? vec_q[xc] - prod_q[VecBits-1:0] : prod_q[VecBits-1:0];
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd5) cnt_q <= 5'd0;
      end
      ST_DACC: begin
        acc_q <= acc_sum;
        if (dc_q == 2'd2) begin
          tr_q[dv_q] <= tr_val;
          dc_q <= 2'd0;
          dv_q <= dv_q + 2'd1;
        end else begin
          dc_q <= dc_q + 2'd1;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb_look_at_view_matrix.sv -----
`timescale 1ns / 1ps
module tb_look_at_view_matrix;

  localparam int FracBits    = 16;
  localparam int NumRandom   = 255;
  localparam int QuietTail   = 40;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 400;
  localparam longint One     = 64'sd1 << FracBits;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic               degen;
    logic               last;
  } view_row_t;

  typedef struct {
    logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } camera_t;

  // Directed setup plus, where obvious, the known outcome.
  typedef struct {
    camera_t          cam;
    bit               known;
    logic signed [31:0] r3_0, r3_1, r3_2;
    bit               degen;
  } directed_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] eye_x_i, eye_y_i, eye_z_i;
  logic signed [31:0] target_x_i, target_y_i, target_z_i;
  logic signed [31:0] upvec_x_i, upvec_y_i, upvec_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         row_index_o;
  logic signed [31:0] col_first_o, col_second_o, col_third_o;
  logic               degenerate_o;
  logic               last_row_o;

  view_row_t pending_rows[$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  bit        quiet_phase;
  bit        timed_out;

  look_at_view_matrix #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .eye_x_i     (eye_x_i),
    .eye_y_i     (eye_y_i),
    .eye_z_i     (eye_z_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .target_z_i  (target_z_i),
    .upvec_x_i   (upvec_x_i),
    .upvec_y_i   (upvec_y_i),
    .upvec_z_i   (upvec_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .col_first_o (col_first_o),
    .col_second_o(col_second_o),
    .col_third_o (col_third_o),
    .degenerate_o(degenerate_o),
    .last_row_o  (last_row_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Bit-serial integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale to a common exponent, then divide each magnitude by the length.
  function automatic bit unit_vector(input longint v[3], output longint n[3]);
    longint unsigned mag[3], peak, sumsq, len, q;
    peak = 0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > peak) peak = mag[i];
      n[i] = 0;
    end
    if (peak == 0) return 1'b0;
    while (peak >= (64'd1 << 30)) begin
      peak >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (peak < (64'd1 << 29)) begin
      peak <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
    len = int_sqrt(sumsq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracBits) + (len >> 1)) / len;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross_product(input longint a[3], input longint b[3],
                                        output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Rounded, negated, saturated translation term.
  function automatic logic signed [31:0] eye_offset(input longint u[3],
                                                    input longint e[3]);
    longint t, f;
    t = u[0] * e[0] + u[1] * e[1] + u[2] * e[2] + (One >>> 1);
    if (t >= 0) f = longint'(longint'(unsigned'(t)) >> FracBits);
    else f = -longint'((longint'(unsigned'(-t)) + (One - 1)) >> FracBits);
    f = -f;
    if (f > 64'sd2147483647) f = 64'sd2147483647;
    if (f < -64'sd2147483648) f = -64'sd2147483648;
    return f[31:0];
  endfunction

  function automatic void predict_view_rows(input camera_t c);
    longint eye[3], dir[3], tmp[3], look[3], right[3], up[3], el[4][3];
    bit ok;
    view_row_t r;
    eye = '{c.ex, c.ey, c.ez};
    dir = '{longint'(c.tx) - c.ex, longint'(c.ty) - c.ey, longint'(c.tz) - c.ez};
    ok = unit_vector(dir, look);
    if (ok) begin
      cross_product('{longint'(c.ux), longint'(c.uy), longint'(c.uz)}, look, tmp);
      ok = unit_vector(tmp, right);
    end
    if (ok) begin
      cross_product(look, right, tmp);
      ok = unit_vector(tmp, up);
    end
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 3; i++)
        el[k][i] = (k == i) ? One : 0;
    if (ok) begin
      for (int k = 0; k < 3; k++) begin
        el[k][0] = right[k];
        el[k][1] = up[k];
        el[k][2] = look[k];
      end
      el[3][0] = eye_offset(right, eye);
      el[3][1] = eye_offset(up, eye);
      el[3][2] = eye_offset(look, eye);
    end
    for (int k = 0; k < 4; k++) begin
      r.row   = k[1:0];
      r.c0    = el[k][0][31:0];
      r.c1    = el[k][1][31:0];
      r.c2    = el[k][2][31:0];
      r.degen = !ok;
      r.last  = (k == 3);
      pending_rows.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Check each row transfer against the oldest expectation.
  always @(posedge clk_i) begin
    view_row_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected row", row_index_o, -1);
      end else begin
        w = pending_rows.pop_front();
        if (row_index_o !== w.row) report_mismatch("row_index", row_index_o, w.row);
        if (col_first_o !== w.c0) report_mismatch("col_first", col_first_o, w.c0);
        if (col_second_o !== w.c1) report_mismatch("col_second", col_second_o, w.c1);
        if (col_third_o !== w.c2) report_mismatch("col_third", col_third_o, w.c2);
        if (degenerate_o !== w.degen)
          report_mismatch("degenerate", degenerate_o, w.degen);
        if (last_row_o !== w.last) report_mismatch("last_row", last_row_o, w.last);
      end
    end
  end

  // Stall the result side in random bursts; none in the quiet tail.
  always @(posedge clk_i) begin
    int burst;
    if (!rst_ni || quiet_phase) begin
      out_stall_i <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      if (burst == 0) out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(1, 10);
      out_stall_i <= 1'b1;
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2:       return $signed($urandom_range(0, 32'h7FF)) - 32'sh400;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic send_camera(input camera_t c);
    eye_x_i    <= c.ex;
    eye_y_i    <= c.ey;
    eye_z_i    <= c.ez;
    target_x_i <= c.tx;
    target_y_i <= c.ty;
    target_z_i <= c.tz;
    upvec_x_i  <= c.ux;
    upvec_y_i  <= c.uy;
    upvec_z_i  <= c.uz;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_view_rows(c);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  directed_t plan[$];

  function automatic camera_t cam(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                  ux, uy, uz);
    camera_t c;
    c.ex = ex; c.ey = ey; c.ez = ez;
    c.tx = tx; c.ty = ty; c.tz = tz;
    c.ux = ux; c.uy = uy; c.uz = uz;
    return c;
  endfunction

  function automatic directed_t known_row(input camera_t c, input bit degen,
                                         input logic signed [31:0] a, b, d);
    directed_t p;
    p.cam = c; p.known = 1'b1; p.degen = degen;
    p.r3_0 = a; p.r3_1 = b; p.r3_2 = d;
    return p;
  endfunction

  function automatic directed_t model_row(input camera_t c);
    directed_t p;
    p.cam = c; p.known = 1'b0; p.degen = 1'b0;
    p.r3_0 = 0; p.r3_1 = 0; p.r3_2 = 0;
    return p;
  endfunction

  localparam logic signed [31:0] Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Min = 32'sh8000_0000;
  localparam logic signed [31:0] Q1  = 32'sh0001_0000;

  initial begin
    camera_t c;
    view_row_t w;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    quiet_phase = 1'b0;
    {eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i} = '0;
    {upvec_x_i, upvec_y_i, upvec_z_i} = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity view, zero-length look, zero-length right, extremes.
    plan.push_back(known_row(cam(0, 0, 0, 0, 0, Q1, 0, Q1, 0), 0, 0, 0, 0));
    plan.push_back(known_row(cam(5, 6, 7, 5, 6, 7, 0, Q1, 0), 1, 0, 0, 0));
    plan.push_back(known_row(cam(0, 0, 0, 0, 0, Q1, 0, 0, Q1), 1, 0, 0, 0));
    plan.push_back(known_row(cam(0, 0, 0, 0, 0, Q1, 0, 0, 0), 1, 0, 0, 0));
    plan.push_back(known_row(cam(Max, Max, Max, Max, Max, Max, Min, Min, Min),
                             1, 0, 0, 0));
    plan.push_back(model_row(cam(Min, Min, Min, Max, Max, Max, 0, Q1, 0)));
    plan.push_back(model_row(cam(Max, Max, Max, Min, Min, Min, Max, Min, Max)));
    plan.push_back(model_row(cam(Max, Min, Max, Min, Max, Min, 0, 0, Max)));
    plan.push_back(model_row(cam(Min, Max, Min, Max, Min, Max, Min, 0, 0)));
    plan.push_back(model_row(cam(0, 0, 0, 1, 0, 0, 0, 1, 0)));
    plan.push_back(model_row(cam(0, 0, 0, 0, 0, 1, 1, 0, 0)));
    plan.push_back(model_row(cam(Min, 0, 0, 0, 0, 0, 0, Max, 0)));
    plan.push_back(model_row(cam(-1, -1, -1, 0, 0, 0, -1, 0, 1)));
    plan.push_back(model_row(cam(32'h1234_5678, -32'sd77, 3, 9, 8, -1, 1, 1, 1)));
    plan.push_back(model_row(cam(0, 0, 0, Q1, Q1, Q1, Max, Max, Max)));

    foreach (plan[i]) begin
      sender_gap();
      send_camera(plan[i].cam);
      if (plan[i].known) begin
        // Override the model with the hand-read outcome for these rows.
        repeat (4) void'(pending_rows.pop_back());
        for (int k = 0; k < 4; k++) begin
          w.row = k[1:0];
          w.c0 = (k == 0 || plan[i].degen) && k == 0 ? Q1 : 0;
          w.c1 = (k == 1) ? Q1 : 0;
          w.c2 = (k == 2) ? Q1 : 0;
          if (k == 3) begin
            w.c0 = plan[i].r3_0; w.c1 = plan[i].r3_1; w.c2 = plan[i].r3_2;
          end
          w.degen = plan[i].degen;
          w.last = (k == 3);
          pending_rows.push_back(w);
        end
      end
    end

    // Hold the sender until every expected row has drained.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);

    for (int n = 0; n < NumRandom; n++) begin
      int mode;
      if (n >= NumRandom - QuietTail) quiet_phase = 1'b1;
      mode = $urandom_range(0, 3);
      c = cam(rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode));
      // Occasionally collapse look, make up parallel to it, or zero up.
      case ($urandom_range(0, 19))
        0: begin c.tx = c.ex; c.ty = c.ey; c.tz = c.ez; end
        1: begin c.ux = c.tx - c.ex; c.uy = c.ty - c.ey; c.uz = c.tz - c.ez; end
        2: begin c.ux = 0; c.uy = 0; c.uz = 0; end
        default: ;
      endcase
      sender_gap();
      send_camera(c);
    end
    in_valid_i <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
